// ----- rtl/core/tsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants of the token scanner
// Scan state encoding, token kind codes, keyword codes and record formats.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 255;
  localparam int unsigned LEN_CAP_INT   = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam logic [7:0]  LEN_CAP       = 8'(LEN_CAP_INT);

  // record queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_IDENT = 11'b000_0000_0010,
    ST_ZERO  = 11'b000_0000_0100,
    ST_OCT   = 11'b000_0000_1000,
    ST_HEX   = 11'b000_0001_0000,
    ST_DEC   = 11'b000_0010_0000,
    ST_STAR  = 11'b000_0100_0000,
    ST_SLASH = 11'b000_1000_0000,
    ST_CMP   = 11'b001_0000_0000,
    ST_BLOCK = 11'b010_0000_0000,
    ST_LINE  = 11'b100_0000_0000
  } scan_state_t;

  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_KEYWORD = 4'd1;
  localparam logic [3:0] KIND_DEC     = 4'd2;
  localparam logic [3:0] KIND_OCT     = 4'd3;
  localparam logic [3:0] KIND_HEX     = 4'd4;
  localparam logic [3:0] KIND_DELIM   = 4'd5;
  localparam logic [3:0] KIND_OP      = 4'd6;
  localparam logic [3:0] KIND_BLOCK   = 4'd7;
  localparam logic [3:0] KIND_LINE    = 4'd8;

  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_THEN = 2'd1;
  localparam logic [1:0] KW_IF   = 2'd2;
  localparam logic [1:0] KW_ELSE = 2'd3;

  // keyword spellings as they sit in the window, newest byte lowest
  localparam logic [31:0] WORD_THEN = 32'h7468_656E;
  localparam logic [31:0] WORD_IF   = 32'h0000_6966;
  localparam logic [31:0] WORD_ELSE = 32'h656C_7365;

  typedef struct packed {
    scan_state_t state;
    logic [7:0]  count;
    logic [7:0]  start;
    logic [31:0] window;
    logic        star;
  } scan_t;

  localparam scan_t SCAN_IDLE = '{ST_IDLE, 8'd0, 8'd0, 32'd0, 1'b0};

  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] keyword_id;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic [7:0] length;
    logic       last;
  } rec_t;

  // up to two records per character; push1 only together with push0
  typedef struct packed {
    logic push0;
    logic push1;
    rec_t rec0;
    rec_t rec1;
  } push_t;

endpackage

// ----- rtl/core/tsc_in_if.sv -----
// ----------------------------------------------------------------------------
// tsc_in_if: character request channel
// One source byte or an end marker per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink   (input valid, input ch, input at_end, output ready);
endinterface

// ----- rtl/core/tsc_out_if.sv -----
// ----------------------------------------------------------------------------
// tsc_out_if: token record channel
// One token record per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [1:0] keyword_id;
  logic [7:0] first_char;
  logic [7:0] second_char;
  logic [7:0] length;
  logic       last;

  modport source (output valid, output kind, output keyword_id, output first_char,
                  output second_char, output length, output last, input ready);
  modport sink   (input valid, input kind, input keyword_id, input first_char,
                  input second_char, input length, input last, output ready);
endinterface

// ----- rtl/core/tsc_step.sv -----
// ----------------------------------------------------------------------------
// tsc_step: scan state update for one character
// Classifies the byte against the current state and produces the next state
// and up to two token records.
// ----------------------------------------------------------------------------
module tsc_step (
  input  tsc_pkg::scan_t cur,
  input  logic [7:0]     ch,
  input  logic           at_end,
  output tsc_pkg::scan_t nxt,
  output tsc_pkg::push_t recs
);
  import tsc_pkg::*;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_E_LO   = 8'h65;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef struct packed {
    logic v;
    rec_t r;
  } opt_rec_t;

  typedef struct packed {
    scan_t    st;
    opt_rec_t rec;
  } idle_res_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic [7:0] bump(logic [7:0] n);
    return (n < LEN_CAP) ? n + 8'd1 : n;
  endfunction

  function automatic opt_rec_t mk(logic [3:0] kind, logic [1:0] kw, logic [7:0] c1,
                                  logic [7:0] c2, logic [7:0] len);
    opt_rec_t o;
    o.v             = 1'b1;
    o.r.kind        = kind;
    o.r.keyword_id  = kw;
    o.r.first_char  = c1;
    o.r.second_char = c2;
    o.r.length      = len;
    o.r.last        = 1'b0;
    return o;
  endfunction

  function automatic scan_t start_st(scan_state_t s, logic [7:0] c);
    scan_t t;
    t       = SCAN_IDLE;
    t.state = s;
    t.start = c;
    t.count = 8'd1;
    return t;
  endfunction

  // pending token closed by a foreign byte or the end marker
  function automatic opt_rec_t flush_rec(scan_t s);
    opt_rec_t   o;
    logic [1:0] kw;
    o  = '0;
    kw = KW_NONE;
    case (s.state)
      ST_IDENT: begin
        if (s.count == 8'd4 && s.window == WORD_THEN)      kw = KW_THEN;
        else if (s.count == 8'd2 && s.window == WORD_IF)   kw = KW_IF;
        else if (s.count == 8'd4 && s.window == WORD_ELSE) kw = KW_ELSE;
        o = mk((kw != KW_NONE) ? KIND_KEYWORD : KIND_IDENT, kw, s.start, 8'd0, s.count);
      end
      ST_ZERO, ST_DEC:           o = mk(KIND_DEC, KW_NONE, s.start, 8'd0, s.count);
      ST_OCT:                    o = mk(KIND_OCT, KW_NONE, s.start, 8'd0, s.count);
      ST_HEX:                    o = mk(KIND_HEX, KW_NONE, s.start, 8'd0, s.count);
      ST_STAR, ST_SLASH, ST_CMP: o = mk(KIND_OP, KW_NONE, s.start, 8'd0, 8'd1);
      ST_BLOCK:                  o = mk(KIND_BLOCK, KW_NONE, CH_SLASH, CH_STAR, s.count);
      ST_LINE:                   o = mk(KIND_LINE, KW_NONE, CH_SLASH, CH_SLASH, s.count);
      default:                   o = '0;
    endcase
    return o;
  endfunction

  // a byte seen between tokens
  function automatic idle_res_t scan_idle(logic [7:0] c);
    idle_res_t res;
    res.st  = SCAN_IDLE;
    res.rec = '0;
    if (is_alpha(c)) begin
      res.st        = start_st(ST_IDENT, c);
      res.st.window = {24'd0, c};
    end else if (c == CH_0) begin
      res.st = start_st(ST_ZERO, c);
    end else if (is_digit(c)) begin
      res.st = start_st(ST_DEC, c);
    end else if (c inside {CH_COMMA, CH_SEMI, CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE}) begin
      res.rec = mk(KIND_DELIM, KW_NONE, c, 8'd0, 8'd1);
    end else if (c inside {CH_PLUS, CH_MINUS}) begin
      res.rec = mk(KIND_OP, KW_NONE, c, 8'd0, 8'd1);
    end else if (c == CH_STAR) begin
      res.st = start_st(ST_STAR, c);
    end else if (c == CH_SLASH) begin
      res.st = start_st(ST_SLASH, c);
    end else if (c inside {CH_EQ, CH_LT, CH_GT}) begin
      res.st = start_st(ST_CMP, c);
    end
    return res;
  endfunction

  idle_res_t  ir;
  opt_rec_t   fr;
  opt_rec_t   a;
  opt_rec_t   b;
  logic       reclass;
  logic [7:0] cnt_up;

  assign ir     = scan_idle(ch);
  assign fr     = flush_rec(cur);
  assign cnt_up = bump(cur.count);

  always_comb begin
    nxt     = cur;
    a       = '0;
    b       = '0;
    reclass = 1'b0;
    if (at_end) begin
      a   = fr;
      nxt = SCAN_IDLE;
    end else begin
      case (cur.state)
        ST_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
            nxt.window = (cur.count < LEN_CAP) ? {cur.window[23:0], ch} : 32'd0;
            nxt.count  = cnt_up;
          end else begin
            reclass = 1'b1;
          end
        end
        ST_ZERO: begin
          if (ch == CH_X_LO || ch == CH_X_UP) begin
            nxt.state = ST_HEX;
            nxt.count = cnt_up;
          end else if (is_digit(ch)) begin
            nxt.state = ST_OCT;
            nxt.count = cnt_up;
          end else begin
            reclass = 1'b1;
          end
        end
        ST_OCT: begin
          if (is_digit(ch)) nxt.count = cnt_up;
          else reclass = 1'b1;
        end
        ST_HEX: begin
          if (is_digit(ch) || is_alpha(ch)) nxt.count = cnt_up;
          else reclass = 1'b1;
        end
        ST_DEC: begin
          if (is_digit(ch) || ch == CH_DOT || ch == CH_E_LO) nxt.count = cnt_up;
          else reclass = 1'b1;
        end
        ST_STAR, ST_CMP: begin
          if (ch == CH_EQ) begin
            a   = mk(KIND_OP, KW_NONE, cur.start, CH_EQ, 8'd2);
            nxt = SCAN_IDLE;
          end else begin
            reclass = 1'b1;
          end
        end
        ST_SLASH: begin
          if (ch == CH_EQ) begin
            a   = mk(KIND_OP, KW_NONE, CH_SLASH, CH_EQ, 8'd2);
            nxt = SCAN_IDLE;
          end else if (ch == CH_STAR) begin
            nxt.state = ST_BLOCK;
            nxt.count = cnt_up;
            nxt.star  = 1'b0;
          end else if (ch == CH_SLASH) begin
            nxt.state = ST_LINE;
            nxt.count = cnt_up;
          end else begin
            reclass = 1'b1;
          end
        end
        ST_BLOCK: begin
          if (cur.star && ch == CH_SLASH) begin
            a   = mk(KIND_BLOCK, KW_NONE, CH_SLASH, CH_STAR, cnt_up);
            nxt = SCAN_IDLE;
          end else begin
            nxt.count = cnt_up;
            nxt.star  = (ch == CH_STAR);
          end
        end
        ST_LINE: begin
          if (ch == CH_NL) begin
            a   = mk(KIND_LINE, KW_NONE, CH_SLASH, CH_SLASH, cur.count);
            nxt = SCAN_IDLE;
          end else begin
            nxt.count = cnt_up;
          end
        end
        default: begin
          nxt = ir.st;
          a   = ir.rec;
        end
      endcase
      // close the pending token, then scan the byte again from idle
      if (reclass) begin
        a   = fr;
        b   = ir.rec;
        nxt = ir.st;
      end
    end
  end

  // pack records to the front and flag the final one
  always_comb begin
    recs = '0;
    if (a.v) begin
      recs.push0 = 1'b1;
      recs.rec0  = a.r;
      if (b.v) begin
        recs.push1     = 1'b1;
        recs.rec1      = b.r;
        recs.rec1.last = 1'b1;
      end else begin
        recs.rec0.last = 1'b1;
      end
    end else if (b.v) begin
      recs.push0     = 1'b1;
      recs.rec0      = b.r;
      recs.rec0.last = 1'b1;
    end
  end

endmodule

// ----- rtl/core/tsc_rec_fifo.sv -----
// ----------------------------------------------------------------------------
// tsc_rec_fifo: token record queue
// Takes up to two records a cycle, hands out one; signals room for two.
// ----------------------------------------------------------------------------
module tsc_rec_fifo (
  input  logic           clk,
  input  logic           rst,
  input  tsc_pkg::push_t push,
  input  logic           pop,
  output logic           room,
  output logic           head_valid,
  output tsc_pkg::rec_t  head
);
  import tsc_pkg::*;

  rec_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic [1:0]       n_push;
  logic             pop_ok;

  assign n_push     = {1'b0, push.push0} + {1'b0, push.push1};
  assign head_valid = (count != '0);
  assign pop_ok     = pop && head_valid;
  assign head       = mem[rd_ptr];
  assign room       = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop_ok) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + CNT_W'(n_push) - CNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) mem[wr_ptr] <= push.rec0;
    if (push.push1) mem[wr_ptr + PTR_W'(1)] <= push.rec1;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("record queue count beyond depth");

  a_double_push: assert property (@(posedge clk) disable iff (rst)
    (push.push0 && push.push1 && !pop_ok) |=> count == $past(count) + CNT_W'(2))
    else $error("double push did not add two records");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.push0 |-> room)
    else $error("record pushed without room for two");
`endif

endmodule

// ----- rtl/core/token_scanner_top.sv -----
// ----------------------------------------------------------------------------
// token_scanner_top: character-serial lexical scanner
// Takes one source byte per request and returns token records.
// ----------------------------------------------------------------------------
// The scanner takes one character per clock cycle while the record queue has
// room. Each accepted request updates the scan state in the same cycle, and
// the records it closes (zero, one, or two when a byte both ends a token and
// forms a token of its own) are registered in a four-entry record queue before
// they are offered on the token channel. The token channel hands out one record
// per cycle while the consumer is ready, so the sustained rate is one character
// per cycle as long as records average at most one per character; a character
// that yields two records needs two handouts on the token port. The character
// channel stays ready while the queue has room for two records, so a stalled
// token consumer holds off input only once the queue holds more than two
// records. An end marker flushes any pending token and returns the scanner to
// idle; there is no startup sweep, the block is ready as soon as reset ends.
// ----------------------------------------------------------------------------
module token_scanner_top (
  input  logic       clk,
  input  logic       rst,
  tsc_in_if.sink     items,
  tsc_out_if.source  tokens
);
  import tsc_pkg::*;

  scan_t cur;
  scan_t nxt;
  push_t recs;
  push_t push;
  rec_t  head;
  logic  head_valid;
  logic  room;
  logic  accept;

  assign accept      = items.valid && items.ready;
  assign items.ready = room;

  // classify the byte against the scan state
  tsc_step u_step (
    .cur    (cur),
    .ch     (items.ch),
    .at_end (items.at_end),
    .nxt    (nxt),
    .recs   (recs)
  );

  // advance the scan state only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= SCAN_IDLE;
    end else if (accept) begin
      cur <= nxt;
    end
  end

  // drop the records of a character that was not accepted
  always_comb begin
    push       = recs;
    push.push0 = recs.push0 && accept;
    push.push1 = recs.push1 && accept;
  end

  tsc_rec_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (tokens.ready),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign tokens.valid       = head_valid;
  assign tokens.kind        = head.kind;
  assign tokens.keyword_id  = head.keyword_id;
  assign tokens.first_char  = head.first_char;
  assign tokens.second_char = head.second_char;
  assign tokens.length      = head.length;
  assign tokens.last        = head.last;

`ifndef ASSERT_OFF
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && items.at_end) |=> cur.state == ST_IDLE)
    else $error("end marker did not return scanner to idle");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (push.push0 && !push.push1) |-> push.rec0.last)
    else $error("single record not flagged last");

  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> (push.rec1.last && !push.rec0.last))
    else $error("record pair flagged wrongly");
`endif

endmodule

// ----- verif/tb_token_scanner_top.sv -----
// ----------------------------------------------------------------------------
// tb_token_scanner_top: self-checking bench for the token scanner
// Feeds character requests and end markers into the scanner and checks every
// token record, field by field, against a predictor that runs the same scan
// rules. The stimulus is a short hand-built sequence followed by randomized
// token text with gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_token_scanner_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsc_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string DIGITS     = "0123456789";
  localparam string ALNUM      = {LETTERS, DIGITS};
  localparam string IDENT_TAIL = {LETTERS, DIGITS, "_"};

  // --------------------------------------------------------------------------
  // Predictor and store of expected token records. take_char runs one request
  // through the scan rules and queues the records it closes; match_token
  // compares an accepted record with the oldest one still due.
  // --------------------------------------------------------------------------
  class token_ledger;
    rec_t        due_tokens[$];
    rec_t        step_recs[$];
    scan_state_t st;
    logic [7:0]  cnt;
    logic [7:0]  first;
    logic [31:0] window;
    logic        star;

    int unsigned mismatches;
    int unsigned chars_taken;
    int unsigned records_checked;
    int unsigned keywords_seen;
    int unsigned longest;
    int unsigned kind_hits[9];

    function new();
      go_idle();
    endfunction

    function int unsigned pending();
      return due_tokens.size();
    endfunction

    function void go_idle();
      st     = ST_IDLE;
      cnt    = 8'd0;
      first  = 8'd0;
      window = 32'd0;
      star   = 1'b0;
    endfunction

    function void begin_token(scan_state_t s, logic [7:0] c);
      st     = s;
      first  = c;
      cnt    = 8'd1;
      window = 32'd0;
      star   = 1'b0;
    endfunction

    function void grow();
      if (cnt < LEN_CAP) cnt++;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    // a single request closes at most two records
    function void push_rec(logic [3:0] k, logic [1:0] kw, logic [7:0] c1, logic [7:0] c2,
                           logic [7:0] len);
      rec_t r;
      if (step_recs.size() >= 2) return;
      r = '{k, kw, c1, c2, len, 1'b0};
      step_recs.push_back(r);
    endfunction

    // keywords need the exact length; a saturated name has a cleared window
    function void close_ident();
      logic [1:0] kw;
      kw = KW_NONE;
      if (cnt == 8'd4 && window == WORD_THEN) kw = KW_THEN;
      else if (cnt == 8'd2 && window == WORD_IF) kw = KW_IF;
      else if (cnt == 8'd4 && window == WORD_ELSE) kw = KW_ELSE;
      push_rec((kw != KW_NONE) ? KIND_KEYWORD : KIND_IDENT, kw, first, 8'h00, cnt);
    endfunction

    // emit whatever token is open, then drop back to idle
    function void flush();
      case (st)
        ST_IDENT: close_ident();
        ST_ZERO, ST_DEC: push_rec(KIND_DEC, KW_NONE, first, 8'h00, cnt);
        ST_OCT: push_rec(KIND_OCT, KW_NONE, first, 8'h00, cnt);
        ST_HEX: push_rec(KIND_HEX, KW_NONE, first, 8'h00, cnt);
        ST_STAR, ST_SLASH, ST_CMP: push_rec(KIND_OP, KW_NONE, first, 8'h00, 8'd1);
        ST_BLOCK: push_rec(KIND_BLOCK, KW_NONE, "/", "*", cnt);
        ST_LINE: push_rec(KIND_LINE, KW_NONE, "/", "/", cnt);
        default: ;
      endcase
      go_idle();
    endfunction

    function void scan_from_idle(logic [7:0] c);
      if (is_letter(c)) begin
        begin_token(ST_IDENT, c);
        window = {24'd0, c};
      end else if (c == "0") begin
        begin_token(ST_ZERO, c);
      end else if (is_digit(c)) begin
        begin_token(ST_DEC, c);
      end else if (c == "," || c == ";" || c == "(" || c == ")" || c == "{" || c == "}") begin
        push_rec(KIND_DELIM, KW_NONE, c, 8'h00, 8'd1);
      end else if (c == "+" || c == "-") begin
        push_rec(KIND_OP, KW_NONE, c, 8'h00, 8'd1);
      end else if (c == "*") begin
        begin_token(ST_STAR, c);
      end else if (c == "/") begin
        begin_token(ST_SLASH, c);
      end else if (c == "=" || c == "<" || c == ">") begin
        begin_token(ST_CMP, c);
      end
      // whitespace and unknown bytes fall through untouched
    endfunction

    function void scan_char(logic [7:0] c);
      bit alnum;
      alnum = is_letter(c) || is_digit(c);
      case (st)
        ST_IDENT: if (alnum || c == "_") begin
          if (cnt < LEN_CAP) window = {window[23:0], c};
          else window = 32'd0;
          grow();
          return;
        end
        ST_ZERO: begin
          if (c == "x" || c == "X") begin
            st = ST_HEX;
            grow();
            return;
          end
          if (is_digit(c)) begin
            st = ST_OCT;
            grow();
            return;
          end
        end
        ST_OCT: if (is_digit(c)) begin
          grow();
          return;
        end
        ST_HEX: if (alnum) begin
          grow();
          return;
        end
        ST_DEC: if (is_digit(c) || c == "." || c == "e") begin
          grow();
          return;
        end
        ST_STAR, ST_CMP: if (c == "=") begin
          push_rec(KIND_OP, KW_NONE, first, "=", 8'd2);
          go_idle();
          return;
        end
        ST_SLASH: begin
          if (c == "=") begin
            push_rec(KIND_OP, KW_NONE, "/", "=", 8'd2);
            go_idle();
            return;
          end
          if (c == "*") begin
            st   = ST_BLOCK;
            star = 1'b0;
            grow();
            return;
          end
          if (c == "/") begin
            st = ST_LINE;
            grow();
            return;
          end
        end
        ST_BLOCK: begin
          grow();
          if (star && c == "/") begin
            push_rec(KIND_BLOCK, KW_NONE, "/", "*", cnt);
            go_idle();
            return;
          end
          star = (c == "*");
          return;
        end
        ST_LINE: begin
          if (c == CH_NL) begin
            push_rec(KIND_LINE, KW_NONE, "/", "/", cnt);
            go_idle();
            return;
          end
          grow();
          return;
        end
        default: begin
          go_idle();
          scan_from_idle(c);
          return;
        end
      endcase
      // the byte closed the open token; scan it again from idle
      flush();
      scan_from_idle(c);
    endfunction

    function void take_char(logic [7:0] c, logic is_end);
      step_recs.delete();
      chars_taken++;
      if (is_end) flush();
      else scan_char(c);
      if (step_recs.size() != 0) step_recs[step_recs.size() - 1].last = 1'b1;
      foreach (step_recs[i]) due_tokens.push_back(step_recs[i]);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_token(rec_t got);
      rec_t want;
      if (due_tokens.size() == 0) begin
        $error("token record with nothing due: kind %0d first_char %0h length %0d",
               got.kind, got.first_char, got.length);
        mismatches++;
        return;
      end
      want = due_tokens.pop_front();
      cmp_field("kind", want.kind, got.kind);
      cmp_field("keyword_id", want.keyword_id, got.keyword_id);
      cmp_field("first_char", want.first_char, got.first_char);
      cmp_field("second_char", want.second_char, got.second_char);
      cmp_field("length", want.length, got.length);
      cmp_field("last", want.last, got.last);
      records_checked++;
      if (want.kind <= KIND_LINE) kind_hits[want.kind]++;
      if (want.kind == KIND_KEYWORD) keywords_seen++;
      if (want.length > longest) longest = want.length;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  tsc_in_if  char_bus ();
  tsc_out_if token_bus ();

  token_scanner_top DUT (
    .clk    (clk),
    .rst    (rst),
    .items  (char_bus),
    .tokens (token_bus)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  token_ledger ledger;

  // idle odds in percent, changed between phases only
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  // bumped by the stimulus to ask the token consumer for one long hold-off
  int unsigned holds_asked = 0;
  int unsigned cycle_count = 0;

  // text of the next random fragment, and whether an end marker follows it
  logic [7:0] frag[$];
  logic       end_after;

  // --------------------------------------------------------------------------
  // Watchdog: give up if the run never settles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Token consumer: random back-pressure, plus a long hold-off on demand that
  // is counted out here so the sender can keep pushing into a full queue.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    token_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        token_bus.ready <= 1'b0;
        hold_left--;
      end else if (holds_taken != holds_asked) begin
        holds_taken = holds_asked;
        hold_left   = HOLD_CYCLES;
        token_bus.ready <= 1'b0;
      end else begin
        token_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the clock edge. A record accepted
  // here always stems from an earlier request, so the check goes first.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rec_t seen;
    if (!rst) begin
      if (token_bus.valid && token_bus.ready) begin
        seen = '{token_bus.kind, token_bus.keyword_id, token_bus.first_char,
                 token_bus.second_char, token_bus.length, token_bus.last};
        ledger.match_token(seen);
      end
      if (char_bus.valid && char_bus.ready) ledger.take_char(char_bus.ch, char_bus.at_end);
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. Valid stays high from one request to the next unless an
  // idle cycle is drawn, so it is never lowered and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic is_end);
    while ($urandom_range(99) < src_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid  <= 1'b1;
    char_bus.ch     <= c;
    char_bus.at_end <= is_end;
    do @(posedge clk); while (!char_bus.ready);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // Drop valid, wait until every due record is in, then let the queue settle.
  task automatic wait_drained();
    char_bus.valid <= 1'b0;
    do @(negedge clk); while (ledger.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random token text
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_from(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == CH_NL) ? " " : c;
  endfunction

  // Mostly well-formed tokens with random bodies; some comments are left open
  // and some fragments are cut short by an end marker.
  function automatic void build_fragment();
    frag.delete();
    end_after = 1'b0;
    case ($urandom_range(19))
      0, 1, 2, 3, 17, 18: begin
        frag.push_back(pick_from(LETTERS));
        repeat ($urandom_range(6)) frag.push_back(pick_from(IDENT_TAIL));
      end
      4, 5: begin
        // keywords and their near misses in case and length
        case ($urandom_range(7))
          0: append_text("then");
          1: append_text("if");
          2: append_text("else");
          3: append_text("the");
          4: append_text("iff");
          5: append_text("Else");
          6: append_text("thens");
          default: append_text("IF");
        endcase
      end
      6, 7: begin
        frag.push_back(pick_from("123456789"));
        repeat ($urandom_range(5)) frag.push_back(pick_from("0123456789.e"));
      end
      8: begin
        frag.push_back("0");
        repeat ($urandom_range(3)) frag.push_back(pick_from(DIGITS));
      end
      9: begin
        frag.push_back("0");
        frag.push_back(pick_from("xX"));
        repeat ($urandom_range(5)) frag.push_back(pick_from(ALNUM));
      end
      10, 11: frag.push_back(pick_from(",;(){}+-"));
      12, 13: begin
        frag.push_back(pick_from("*/=<>"));
        if ($urandom_range(1) != 0) frag.push_back("=");
      end
      14: begin
        append_text("/*");
        repeat ($urandom_range(8)) frag.push_back(pick_from("ab*/ \n"));
        if ($urandom_range(5) != 0) append_text("*/");
      end
      15: begin
        append_text("//");
        repeat ($urandom_range(8)) frag.push_back(any_but_newline());
        frag.push_back(CH_NL);
      end
      default: repeat ($urandom_range(3, 1)) frag.push_back(8'($urandom_range(255)));
    endcase

    if ($urandom_range(24) == 0) begin
      // cut the token short and end the input mid-token
      repeat ($urandom_range(frag.size() - 1)) void'(frag.pop_back());
      end_after = 1'b1;
    end else begin
      case ($urandom_range(9))
        0, 1: ;
        2, 3, 4: frag.push_back(" ");
        5: frag.push_back(CH_NL);
        6: frag.push_back(CH_TAB);
        7: frag.push_back(pick_from("#$@_!?~\\"));
        8: end_after = 1'b1;
        default: frag.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  // One token long enough to saturate the length count.
  function automatic void build_long();
    int unsigned n;
    frag.delete();
    end_after = 1'b0;
    n = $urandom_range(262, 256);
    case ($urandom_range(3))
      0: begin
        frag.push_back(pick_from(LETTERS));
        repeat (n) frag.push_back(pick_from(IDENT_TAIL));
        append_text("else");
      end
      1: begin
        frag.push_back("7");
        repeat (n) frag.push_back(pick_from(DIGITS));
      end
      2: begin
        append_text("/*");
        repeat (n) frag.push_back(pick_from("ab *"));
        append_text("*/");
      end
      default: begin
        append_text("//");
        repeat (n) frag.push_back(pick_from(ALNUM));
        frag.push_back(CH_NL);
      end
    endcase
    frag.push_back(" ");
  endfunction

  task automatic send_fragment();
    foreach (frag[i]) send_char(frag[i], 1'b0);
    if (end_after) send_char(8'($urandom_range(255)), 1'b1);
  endtask

  // One phase of random text under the given idle odds; press asks the
  // consumer for a long hold-off while requests keep coming.
  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                           input bit press);
    int unsigned sent;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    if (press) holds_asked++;
    build_long();
    send_fragment();
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      build_fragment();
      send_fragment();
      sent += frag.size() + end_after;
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    ledger = new();
    src_idle_pct = 20;
    snk_idle_pct = 59;
    rst <= 1'b1;
    char_bus.valid  <= 1'b0;
    char_bus.ch     <= 8'd0;
    char_bus.at_end <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Hand-built text: "if" closed by a delimiter, octal, lone zero, hex
    // closed by a compare that takes '=', a decimal with exponent closed by
    // '/', a block comment whose opening star does not count toward its end,
    // a single '*' closed by '+', a line comment holding 0xFF, an unknown
    // 0x00, "else" flushed by an end marker, and an end marker while idle.
    send_string("if(07)0,0xF<=9e/*/*/*+//");
    send_char(8'hFF, 1'b0);
    send_char(CH_NL, 1'b0);
    send_char(8'h00, 1'b0);
    send_string("else");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    wait_drained();

    // Slow consumer, then slow producer, then full speed with a long stall.
    run_phase(20, 59, 1'b0);
    run_phase(59, 20, 1'b0);
    run_phase(0, 0, 1'b1);

    $display("summary: %0d requests, %0d records checked, %0d keywords, longest token %0d",
             ledger.chars_taken, ledger.records_checked, ledger.keywords_seen, ledger.longest);
    $display("summary: records by kind (ident..line comment) %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             ledger.kind_hits[0], ledger.kind_hits[1], ledger.kind_hits[2],
             ledger.kind_hits[3], ledger.kind_hits[4], ledger.kind_hits[5],
             ledger.kind_hits[6], ledger.kind_hits[7], ledger.kind_hits[8]);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
